[sv/ralloc_pkg.sv]
// ----------------------------------------------------------------------------
// ralloc_pkg
// Shared sizes, codes, command and result types of the resource allocator.
// ----------------------------------------------------------------------------
package ralloc_pkg;

  localparam int REQUESTERS = 4;
  localparam int RESOURCES  = 2;

  localparam int REQ_IW = (REQUESTERS > 1) ? $clog2(REQUESTERS) : 1;
  localparam int RES_IW = (RESOURCES > 1) ? $clog2(RESOURCES) : 1;

  localparam int OP_W  = 2;
  localparam int REQ_W = 2;
  localparam int RES_W = 1;
  localparam int TMO_W = 8;

  // Command queue depth and result queue depth, both powers of two.
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);

  localparam logic [OP_W-1:0] OP_REQUEST = 2'd0;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK    = 2'd2;

  typedef logic [1:0] cmd_kind_t;
  localparam cmd_kind_t CMD_NOP  = 2'd0;
  localparam cmd_kind_t CMD_REQ  = 2'd1;
  localparam cmd_kind_t CMD_REL  = 2'd2;
  localparam cmd_kind_t CMD_TICK = 2'd3;

  localparam logic EV_GRANT   = 1'b0;
  localparam logic EV_TIMEOUT = 1'b1;

  typedef logic [REQUESTERS-1:0] req_mask_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [REQ_IW-1:0]  req;
    logic [RES_IW-1:0]  res;
    logic [TMO_W-1:0]   tmo;
  } cmd_t;

  typedef struct packed {
    logic              kind;
    logic [REQ_W-1:0]  target;
    logic [RES_W-1:0]  res;
    logic              last;
  } result_t;

  // Index of the lowest set bit; zero when no bit is set.
  function automatic logic [REQ_IW-1:0] lowest_idx(input req_mask_t m);
    logic [REQ_IW-1:0] idx;
    idx = '0;
    for (int i = REQUESTERS - 1; i >= 0; i--) begin
      if (m[i]) idx = REQ_IW'(i);
    end
    return idx;
  endfunction

endpackage

[sv/ralloc_front.sv]
// ----------------------------------------------------------------------------
// ralloc_front
// Input side: decode and range-check each item, hold it in a short queue.
// ----------------------------------------------------------------------------
module ralloc_front
  import ralloc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  input  logic [OP_W-1:0]  in_op,
  input  logic [REQ_W-1:0] in_requester,
  input  logic [RES_W-1:0] in_resource,
  input  logic [TMO_W-1:0] in_timeout,
  output logic             in_full,
  output logic             cmd_valid,
  output cmd_t             cmd,
  input  logic             cmd_pop
);

  cmd_t               q_r [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CMDQ_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CMDQ_AW:0]   cnt_r, cnt_nxt;
  logic               do_push, do_pop, idx_ok;
  cmd_t               dec;

  assign in_full   = (cnt_r == (CMDQ_AW+1)'(CMDQ_DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rd_ptr_r];
  assign do_push   = in_push && !in_full;
  assign do_pop    = cmd_pop && cmd_valid;

  // Classify; out-of-range indexes turn a request or release into a no-op.
  always_comb begin
    idx_ok   = (32'(in_requester) < REQUESTERS) && (32'(in_resource) < RESOURCES);
    dec.req  = REQ_IW'(in_requester);
    dec.res  = RES_IW'(in_resource);
    dec.tmo  = in_timeout;
    case (in_op)
      OP_REQUEST: dec.kind = idx_ok ? CMD_REQ : CMD_NOP;
      OP_RELEASE: dec.kind = idx_ok ? CMD_REL : CMD_NOP;
      OP_TICK:    dec.kind = CMD_TICK;
      default:    dec.kind = CMD_NOP;
    endcase
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + CMDQ_AW'(do_push);
    rd_ptr_nxt = rd_ptr_r + CMDQ_AW'(do_pop);
    cnt_nxt    = cnt_r + (CMDQ_AW+1)'(do_push) - (CMDQ_AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

endmodule

[sv/ralloc_back.sv]
// ----------------------------------------------------------------------------
// ralloc_back
// Execution side: owns holder, wait and countdown state, emits result beats.
// ----------------------------------------------------------------------------
module ralloc_back
  import ralloc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    cmd_valid,
  input  cmd_t    cmd,
  output logic    cmd_pop,
  input  logic    res_ready,
  output logic    res_valid,
  output result_t res
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EMIT = 1'b1;

  logic                  state_r, state_nxt;
  logic [RESOURCES-1:0]  holder_busy_r, holder_busy_nxt;
  logic [REQ_IW-1:0]     holder_idx_r [RESOURCES];
  logic [REQ_IW-1:0]     holder_idx_nxt [RESOURCES];
  req_mask_t             wait_valid_r, wait_valid_nxt;
  logic [RES_IW-1:0]     wait_res_r [REQUESTERS];
  logic [RES_IW-1:0]     wait_res_nxt [REQUESTERS];
  logic [TMO_W-1:0]      countdown_r [REQUESTERS];
  logic [TMO_W-1:0]      countdown_nxt [REQUESTERS];
  req_mask_t             mask_r, mask_nxt;
  req_mask_t             on_res, fire, mask_rest;
  logic [REQ_IW-1:0]     win;

  // Waiters on the addressed resource, and waiters whose countdown ran out.
  always_comb begin
    for (int i = 0; i < REQUESTERS; i++) begin
      on_res[i] = wait_valid_r[i] && (wait_res_r[i] == cmd.res);
      fire[i]   = wait_valid_r[i] && (countdown_r[i] == '0);
    end
    mask_rest = mask_r & (mask_r - REQUESTERS'(1));
  end

  always_comb begin
    state_nxt       = state_r;
    holder_busy_nxt = holder_busy_r;
    holder_idx_nxt  = holder_idx_r;
    wait_valid_nxt  = wait_valid_r;
    wait_res_nxt    = wait_res_r;
    countdown_nxt   = countdown_r;
    mask_nxt        = mask_r;
    cmd_pop         = 1'b0;
    res_valid       = 1'b0;
    res             = '0;
    win             = '0;
    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          case (cmd.kind)
            CMD_REQ: begin
              if (!holder_busy_r[cmd.res]) begin
                if (res_ready) begin
                  res_valid                   = 1'b1;
                  res                         = '{EV_GRANT, REQ_W'(cmd.req),
                                                  RES_W'(cmd.res), 1'b1};
                  wait_valid_nxt[cmd.req]     = 1'b0;
                  holder_busy_nxt[cmd.res]    = 1'b1;
                  holder_idx_nxt[cmd.res]     = cmd.req;
                  cmd_pop                     = 1'b1;
                end
              end else begin
                wait_valid_nxt[cmd.req] = 1'b1;
                wait_res_nxt[cmd.req]   = cmd.res;
                countdown_nxt[cmd.req]  = cmd.tmo;
                cmd_pop                 = 1'b1;
              end
            end
            CMD_REL: begin
              if (holder_busy_r[cmd.res] && (holder_idx_r[cmd.res] == cmd.req)) begin
                if (on_res != '0) begin
                  win = lowest_idx(on_res);
                  if (res_ready) begin
                    res_valid               = 1'b1;
                    res                     = '{EV_GRANT, REQ_W'(win),
                                                RES_W'(cmd.res), 1'b1};
                    wait_valid_nxt[win]     = 1'b0;
                    countdown_nxt[win]      = '0;
                    holder_idx_nxt[cmd.res] = win;
                    cmd_pop                 = 1'b1;
                  end
                end else begin
                  holder_busy_nxt[cmd.res] = 1'b0;
                  cmd_pop                  = 1'b1;
                end
              end else begin
                cmd_pop = 1'b1;
              end
            end
            CMD_TICK: begin
              for (int i = 0; i < REQUESTERS; i++) begin
                if (countdown_r[i] != '0) countdown_nxt[i] = countdown_r[i] - TMO_W'(1);
              end
              wait_valid_nxt = wait_valid_r & ~fire;
              if (fire != '0) begin
                mask_nxt  = fire;
                state_nxt = S_EMIT;
              end
              cmd_pop = 1'b1;
            end
            default: begin
              cmd_pop = 1'b1;
            end
          endcase
        end
      end
      S_EMIT: begin
        // Emit timed-out waiters lowest index first, one beat a cycle while res_ready is high.
        win = lowest_idx(mask_r);
        if (res_ready) begin
          res_valid = 1'b1;
          res       = '{EV_TIMEOUT, REQ_W'(win), RES_W'(wait_res_r[win]),
                        (mask_rest == '0)};
          mask_nxt  = mask_rest;
          if (mask_rest == '0) state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      holder_busy_r <= '0;
      wait_valid_r  <= '0;
      mask_r        <= '0;
      for (int i = 0; i < REQUESTERS; i++) begin
        wait_res_r[i]  <= '0;
        countdown_r[i] <= '0;
      end
      for (int j = 0; j < RESOURCES; j++) begin
        holder_idx_r[j] <= '0;
      end
    end else begin
      state_r       <= state_nxt;
      holder_busy_r <= holder_busy_nxt;
      wait_valid_r  <= wait_valid_nxt;
      mask_r        <= mask_nxt;
      wait_res_r    <= wait_res_nxt;
      countdown_r   <= countdown_nxt;
      holder_idx_r  <= holder_idx_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_emit_mask_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (mask_r != '0))
    else $error("timeout emit phase with nothing pending");

  a_fired_not_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> ((mask_r & wait_valid_r) == '0))
    else $error("timed-out requester still marked waiting");

  a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_ready && res.last) |=> (state_r == S_IDLE))
    else $error("final beat did not return sequencer to idle");

  a_no_pop_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> !cmd_pop)
    else $error("command taken while timeout beats pending");
`endif

endmodule

[sv/ralloc_outq.sv]
// ----------------------------------------------------------------------------
// ralloc_outq
// Result queue: buffers result beats until the consumer pops them.
// ----------------------------------------------------------------------------
module ralloc_outq
  import ralloc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t din,
  output logic    full,
  output logic    empty,
  input  logic    pop,
  output result_t dout
);

  result_t            q_r [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [OUTQ_AW:0]   cnt_r;
  logic               do_push, do_pop;

  assign full    = (cnt_r == (OUTQ_AW+1)'(OUTQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign dout    = q_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + OUTQ_AW'(do_push);
      rd_ptr_r <= rd_ptr_r + OUTQ_AW'(do_pop);
      cnt_r    <= cnt_r + (OUTQ_AW+1)'(do_push) - (OUTQ_AW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= din;
    end
  end

endmodule

[sv/resource_allocator_with_timeout.sv]
// ----------------------------------------------------------------------------
// resource_allocator_with_timeout
// Shares a few resources among requesters, with timed-out waits.
// ----------------------------------------------------------------------------
// Items enter through a push/full queue port and results leave through an
// empty/pop queue port. An item is a request, a release or a tick. A request
// for a free resource yields one grant beat; for a held resource the
// requester waits with its countdown loaded from the timeout field. A release
// by the holder hands the resource to the lowest-numbered waiter on it (one
// grant beat) or frees it. A tick decrements every nonzero countdown and
// wakes each waiter whose countdown was already zero, one timeout beat each
// in rising requester order. The last beat of an item carries last=1; items
// that cause nothing produce no beat. A two-entry command queue decouples
// the decode front from the execution sequencer, and a four-entry result
// queue decouples the sequencer from the consumer. The sequencer handles a
// request, release or quiet tick in its idle state; a tick that wakes
// waiters moves it to an emit state, which writes one timeout beat per cycle
// into the result queue while it is not full. The sequencer stalls only when
// the result queue is full. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module resource_allocator_with_timeout
  import ralloc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  output logic             in_full,
  input  logic [OP_W-1:0]  in_op,
  input  logic [REQ_W-1:0] in_requester,
  input  logic [RES_W-1:0] in_resource,
  input  logic [TMO_W-1:0] in_timeout,
  output logic             out_empty,
  input  logic             out_pop,
  output logic             out_event_kind,
  output logic [REQ_W-1:0] out_target,
  output logic [RES_W-1:0] out_event_resource,
  output logic             out_last
);

  logic    cmd_valid, cmd_pop;
  cmd_t    cmd;
  logic    res_valid, outq_full;
  result_t res, head;

  // Front: decode, range check, command queue.
  ralloc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_op        (in_op),
    .in_requester (in_requester),
    .in_resource  (in_resource),
    .in_timeout   (in_timeout),
    .in_full      (in_full),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop)
  );

  // Back: allocation state and result sequencing; hold while results back up.
  ralloc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_ready (!outq_full),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result queue toward the consumer.
  ralloc_outq u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_valid),
    .din   (res),
    .full  (outq_full),
    .empty (out_empty),
    .pop   (out_pop),
    .dout  (head)
  );

  assign out_event_kind     = head.kind;
  assign out_target         = head.target;
  assign out_event_resource = head.res;
  assign out_last           = head.last;

endmodule
